// ===== rtl/sll_pkg.sv =====
// Shared types, token codes and helper functions for the small-language lexer.
// Self-contained; imported by small_language_lexer_top and token_checker.
`timescale 1ns / 1ps
`default_nettype none

package sll_pkg;

  // Run-length limits, capped by the 11-byte lexeme buffer
  localparam int BufDepth       = 11;
  localparam int IdentLimitCfg  = 11;
  localparam int NumberLimitCfg = 5;
  localparam int IdentLimit     = (IdentLimitCfg < BufDepth) ? IdentLimitCfg : BufDepth;
  localparam int NumberLimit    = (NumberLimitCfg < BufDepth) ? NumberLimitCfg : BufDepth;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_IDENT   = 4'd1,
    MODE_IDSKIP  = 4'd2,
    MODE_NUM     = 4'd3,
    MODE_NUMSKIP = 4'd4,
    MODE_SLASH   = 4'd5,
    MODE_COMMENT = 4'd6,
    MODE_COLON   = 4'd7,
    MODE_LESS    = 4'd8,
    MODE_GREATER = 4'd9
  } mode_t;

  // Token codes
  localparam logic [5:0] TokError   = 6'd0;
  localparam logic [5:0] TokMod     = 6'd1;
  localparam logic [5:0] TokIdent   = 6'd2;
  localparam logic [5:0] TokNumber  = 6'd3;
  localparam logic [5:0] TokPlus    = 6'd4;
  localparam logic [5:0] TokMinus   = 6'd5;
  localparam logic [5:0] TokStar    = 6'd6;
  localparam logic [5:0] TokSlash   = 6'd7;
  localparam logic [5:0] TokFi      = 6'd8;
  localparam logic [5:0] TokEq      = 6'd9;
  localparam logic [5:0] TokNe      = 6'd10;
  localparam logic [5:0] TokLt      = 6'd11;
  localparam logic [5:0] TokLe      = 6'd12;
  localparam logic [5:0] TokGt      = 6'd13;
  localparam logic [5:0] TokGe      = 6'd14;
  localparam logic [5:0] TokLParen  = 6'd15;
  localparam logic [5:0] TokRParen  = 6'd16;
  localparam logic [5:0] TokComma   = 6'd17;
  localparam logic [5:0] TokSemi    = 6'd18;
  localparam logic [5:0] TokPeriod  = 6'd19;
  localparam logic [5:0] TokBecomes = 6'd20;
  localparam logic [5:0] TokBegin   = 6'd21;
  localparam logic [5:0] TokEnd     = 6'd22;
  localparam logic [5:0] TokIf      = 6'd23;
  localparam logic [5:0] TokThen    = 6'd24;
  localparam logic [5:0] TokWhile   = 6'd25;
  localparam logic [5:0] TokDo      = 6'd26;
  localparam logic [5:0] TokConst   = 6'd28;
  localparam logic [5:0] TokVar     = 6'd29;
  localparam logic [5:0] TokWrite   = 6'd31;
  localparam logic [5:0] TokRead    = 6'd32;
  localparam logic [5:0] TokElse    = 6'd33;

  // Error kinds
  localparam logic [1:0] ErrNone      = 2'd0;
  localparam logic [1:0] ErrSymbol    = 2'd1;
  localparam logic [1:0] ErrIdentLong = 2'd2;
  localparam logic [1:0] ErrNumLong   = 2'd3;

  typedef logic [BufDepth-1:0][7:0] lexbuf_t;

  typedef struct packed {
    logic [5:0]  token_code;
    logic [1:0]  error_kind;
    logic [3:0]  lexeme_length;
    logic [63:0] lexeme_head;
    logic [23:0] lexeme_tail;
    logic        last_of_run;
  } res_t;

  // Token carrying the first len bytes of the buffer, zero beyond
  function automatic res_t tok_buf(logic [5:0] code, logic [1:0] kind, lexbuf_t b,
                                   logic [3:0] len);
    logic [BufDepth*8-1:0] lex;
    res_t r;
    lex = '0;
    for (int i = 0; i < BufDepth; i++) begin
      if (4'(i) < len) lex[8*i +: 8] = b[i];
    end
    r.token_code    = code;
    r.error_kind    = kind;
    r.lexeme_length = len;
    r.lexeme_head   = lex[63:0];
    r.lexeme_tail   = lex[87:64];
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic res_t tok_one(logic [5:0] code, logic [1:0] kind, logic [7:0] ch);
    res_t r;
    r.token_code    = code;
    r.error_kind    = kind;
    r.lexeme_length = 4'd1;
    r.lexeme_head   = {56'h0, ch};
    r.lexeme_tail   = 24'h0;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic res_t tok_two(logic [5:0] code, logic [7:0] a, logic [7:0] b);
    res_t r;
    r.token_code    = code;
    r.error_kind    = ErrNone;
    r.lexeme_length = 4'd2;
    r.lexeme_head   = {48'h0, b, a};
    r.lexeme_tail   = 24'h0;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  // Word w is right-aligned, first character in the highest used byte
  function automatic logic kw_hit(lexbuf_t b, logic [3:0] len, logic [39:0] w,
                                  logic [3:0] wl);
    logic hit;
    hit = (len == wl);
    for (int i = 0; i < 5; i++) begin
      if (4'(i) < wl) hit = hit & (b[i] == w[8*(int'(wl)-1-i) +: 8]);
    end
    return hit;
  endfunction

  function automatic logic [5:0] word_code(lexbuf_t b, logic [3:0] len);
    logic [5:0] code;
    code = TokIdent;
    if      (kw_hit(b, len, 40'("const"), 4'd5)) code = TokConst;
    else if (kw_hit(b, len, 40'("var"),   4'd3)) code = TokVar;
    else if (kw_hit(b, len, 40'("begin"), 4'd5)) code = TokBegin;
    else if (kw_hit(b, len, 40'("end"),   4'd3)) code = TokEnd;
    else if (kw_hit(b, len, 40'("if"),    4'd2)) code = TokIf;
    else if (kw_hit(b, len, 40'("fi"),    4'd2)) code = TokFi;
    else if (kw_hit(b, len, 40'("then"),  4'd4)) code = TokThen;
    else if (kw_hit(b, len, 40'("else"),  4'd4)) code = TokElse;
    else if (kw_hit(b, len, 40'("while"), 4'd5)) code = TokWhile;
    else if (kw_hit(b, len, 40'("do"),    4'd2)) code = TokDo;
    else if (kw_hit(b, len, 40'("read"),  4'd4)) code = TokRead;
    else if (kw_hit(b, len, 40'("write"), 4'd5)) code = TokWrite;
    else if (kw_hit(b, len, 40'("mod"),   4'd3)) code = TokMod;
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/small_language_lexer_top.sv =====
// Small-language lexer: one source byte per request in, finished tokens out.
// Depends on sll_pkg (types, token codes, keyword match).
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------------------
//   in      | in_valid/in_stall  | input_char, end_of_input
//   out     | out_valid/out_stall| token_code, error_kind, lexeme_length,
//           |                    | lexeme_head, lexeme_tail, last_of_run
//
// An input request is scanned in the cycle it is accepted; its 0, 1 or 2 tokens
// land in a 4-entry result queue and leave it one per cycle while out_stall is low.
// Sustained rate: one request per cycle while each gives at most one token and
// out_stall is low; requests giving two tokens fill the queue, as the single output port drains one per cycle.
// in_stall rises when the queue holds 3 or more tokens.
// Synchronous reset returns the scanner to idle and empties the queue.
`timescale 1ns / 1ps
`default_nettype none

module small_language_lexer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  input_char,
  input  wire logic        end_of_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       token_code,
  output logic [1:0]       error_kind,
  output logic [3:0]       lexeme_length,
  output logic [63:0]      lexeme_head,
  output logic [23:0]      lexeme_tail,
  output logic             last_of_run
);
  import sll_pkg::*;

  localparam logic [3:0] IdentLim = 4'(IdentLimit);
  localparam logic [3:0] NumLim   = 4'(NumberLimit);

  // Scanner state
  mode_t      mode, mode_next;
  logic       prior_star, prior_star_next;
  logic [3:0] count, count_next;
  lexbuf_t    lex_buf;
  logic       wr_en;
  logic [3:0] wr_idx;

  // Result queue
  res_t       fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] cnt;

  logic       in_acc, out_acc;
  logic [7:0] c;
  logic       eoi;

  assign c      = input_char;
  assign eoi    = end_of_input;
  assign in_acc = in_valid & ~in_stall;

  // Character classes
  logic       is_alpha, is_digit, is_alnum, is_space, is_lead;
  logic [5:0] op_code;

  assign is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  assign is_digit = (c >= "0" && c <= "9");
  assign is_alnum = is_alpha | is_digit;
  assign is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
  assign is_lead  = (c == "/") || (c == ":") || (c == "<") || (c == ">");

  always_comb begin
    case (c)
      "+":     op_code = TokPlus;
      "-":     op_code = TokMinus;
      "*":     op_code = TokStar;
      "(":     op_code = TokLParen;
      ")":     op_code = TokRParen;
      "=":     op_code = TokEq;
      ",":     op_code = TokComma;
      ".":     op_code = TokPeriod;
      ";":     op_code = TokSemi;
      default: op_code = TokError;
    endcase
  end

  // Token from starting a new lexeme with c
  logic st_emit;
  res_t st_tok;
  assign st_emit = ~is_space & ~is_alnum & ~is_lead;
  assign st_tok  = (op_code != TokError) ? tok_one(op_code, ErrNone, c)
                                         : tok_one(TokError, ErrSymbol, c);

  // Tokens that close the pending lexeme, and whether c starts a new one
  logic pre_v, sec_v, do_start;
  res_t pre_tok, sec_tok;

  always_comb begin
    pre_v    = 1'b0;
    sec_v    = 1'b0;
    do_start = 1'b0;
    pre_tok  = tok_buf(word_code(lex_buf, count), ErrNone, lex_buf, count);
    sec_tok  = tok_one(TokStar, ErrNone, "*");
    if (eoi) begin
      case (mode)
        MODE_IDENT: pre_v = 1'b1;
        MODE_NUM: begin
          pre_v   = 1'b1;
          pre_tok = tok_buf(TokNumber, ErrNone, lex_buf, count);
        end
        MODE_SLASH: begin
          pre_v   = 1'b1;
          pre_tok = tok_one(TokSlash, ErrNone, "/");
        end
        MODE_COMMENT: begin
          pre_v   = 1'b1;
          pre_tok = tok_one(TokSlash, ErrNone, "/");
          sec_v   = 1'b1;
        end
        MODE_COLON: begin
          pre_v   = 1'b1;
          pre_tok = tok_one(TokError, ErrSymbol, ":");
        end
        MODE_LESS: begin
          pre_v   = 1'b1;
          pre_tok = tok_one(TokLt, ErrNone, "<");
        end
        MODE_GREATER: begin
          pre_v   = 1'b1;
          pre_tok = tok_one(TokGt, ErrNone, ">");
        end
        default: pre_v = 1'b0;
      endcase
    end else begin
      case (mode)
        MODE_IDENT: begin
          if (is_alnum) begin
            if (count >= IdentLim) begin
              pre_v   = 1'b1;
              pre_tok = tok_buf(TokError, ErrIdentLong, lex_buf, count);
            end
          end else begin
            pre_v    = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_IDSKIP: do_start = ~is_alnum;
        MODE_NUM: begin
          pre_tok = tok_buf(TokNumber, ErrNone, lex_buf, count);
          if (is_digit) begin
            if (count >= NumLim) begin
              pre_v   = 1'b1;
              pre_tok = tok_buf(TokError, ErrNumLong, lex_buf, count);
            end
          end else begin
            pre_v    = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_NUMSKIP: do_start = ~is_digit;
        MODE_SLASH: begin
          pre_tok = tok_one(TokSlash, ErrNone, "/");
          if (c != "*") begin
            pre_v    = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_COMMENT: do_start = 1'b0;
        MODE_COLON: begin
          pre_v = 1'b1;
          if (c == "=") begin
            pre_tok = tok_two(TokBecomes, ":", "=");
          end else begin
            pre_tok  = tok_one(TokError, ErrSymbol, ":");
            do_start = 1'b1;
          end
        end
        MODE_LESS: begin
          pre_v = 1'b1;
          if (c == "=") begin
            pre_tok = tok_two(TokLe, "<", "=");
          end else if (c == ">") begin
            pre_tok = tok_two(TokNe, "<", ">");
          end else begin
            pre_tok  = tok_one(TokLt, ErrNone, "<");
            do_start = 1'b1;
          end
        end
        MODE_GREATER: begin
          pre_v = 1'b1;
          if (c == "=") begin
            pre_tok = tok_two(TokGe, ">", "=");
          end else begin
            pre_tok  = tok_one(TokGt, ErrNone, ">");
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase
    end
  end

  // Next scanner state
  always_comb begin
    mode_next       = mode;
    prior_star_next = prior_star;
    count_next      = count;
    wr_en           = 1'b0;
    wr_idx          = count;
    if (eoi) begin
      mode_next       = MODE_IDLE;
      prior_star_next = 1'b0;
      count_next      = 4'd0;
    end else begin
      case (mode)
        MODE_IDENT: begin
          if (is_alnum) begin
            if (count < IdentLim) begin
              wr_en      = 1'b1;
              count_next = count + 4'd1;
            end else begin
              mode_next = MODE_IDSKIP;
            end
          end
        end
        MODE_NUM: begin
          if (is_digit) begin
            if (count < NumLim) begin
              wr_en      = 1'b1;
              count_next = count + 4'd1;
            end else begin
              mode_next = MODE_NUMSKIP;
            end
          end
        end
        MODE_SLASH: begin
          if (c == "*") begin
            mode_next       = MODE_COMMENT;
            prior_star_next = 1'b0;
          end
        end
        MODE_COMMENT: begin
          if (prior_star && c == "/") begin
            mode_next       = MODE_IDLE;
            prior_star_next = 1'b0;
          end else begin
            prior_star_next = (c == "*");
          end
        end
        MODE_COLON, MODE_LESS, MODE_GREATER: mode_next = MODE_IDLE;
        default: mode_next = mode;
      endcase
      if (do_start) begin
        if (is_space) begin
          mode_next = MODE_IDLE;
        end else if (is_alpha) begin
          mode_next = MODE_IDENT;
        end else if (is_digit) begin
          mode_next = MODE_NUM;
        end else begin
          case (c)
            "/":     mode_next = MODE_SLASH;
            ":":     mode_next = MODE_COLON;
            "<":     mode_next = MODE_LESS;
            ">":     mode_next = MODE_GREATER;
            default: mode_next = MODE_IDLE;
          endcase
        end
        if (is_alnum) begin
          wr_en      = 1'b1;
          wr_idx     = 4'd0;
          count_next = 4'd1;
        end
      end
    end
  end

  // Assemble up to two results in order
  logic       v0, v1;
  res_t       r0, r1;
  logic [1:0] push;

  always_comb begin
    v0 = pre_v | (do_start & st_emit);
    v1 = sec_v | (pre_v & do_start & st_emit);
    r0 = pre_v ? pre_tok : st_tok;
    r1 = sec_v ? sec_tok : st_tok;
    r0.last_of_run = ~v1;
    r1.last_of_run = 1'b1;
    push = in_acc ? ({1'b0, v0} + {1'b0, v1}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      prior_star <= 1'b0;
      count      <= 4'd0;
    end else if (in_acc) begin
      mode       <= mode_next;
      prior_star <= prior_star_next;
      count      <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BufDepth; i++) begin
      if (in_acc && wr_en && wr_idx == 4'(i)) lex_buf[i] <= c;
    end
  end

  // Result queue
  assign out_acc   = out_valid & ~out_stall;
  assign out_valid = (cnt != 3'd0);
  assign in_stall  = (cnt >= 3'd3);

  always_ff @(posedge clk) begin
    if (push != 2'd0) fifo[wr_ptr] <= r0;
    if (push == 2'd2) fifo[wr_ptr + 2'd1] <= r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      cnt    <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push;
      rd_ptr <= rd_ptr + {1'b0, out_acc};
      cnt    <= cnt + {1'b0, push} - {2'b0, out_acc};
    end
  end

  assign token_code    = fifo[rd_ptr].token_code;
  assign error_kind    = fifo[rd_ptr].error_kind;
  assign lexeme_length = fifo[rd_ptr].lexeme_length;
  assign lexeme_head   = fifo[rd_ptr].lexeme_head;
  assign lexeme_tail   = fifo[rd_ptr].lexeme_tail;
  assign last_of_run   = fifo[rd_ptr].last_of_run;

`ifndef SYNTHESIS
  a_queue_depth: assert property (@(posedge clk) disable iff (rst) cnt <= 3'd4)
    else $error("result queue overflow");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDENT || mode == MODE_NUM) |-> (count >= 4'd1 && count <= 4'(BufDepth)))
    else $error("lexeme count out of range in a run");

  a_star_in_comment: assert property (@(posedge clk) disable iff (rst)
    prior_star |-> mode == MODE_COMMENT)
    else $error("star flag set outside a comment");

  a_eoi_flush: assert property (@(posedge clk) disable iff (rst)
    (in_acc && end_of_input) |=> (mode == MODE_IDLE && count == 4'd0 && !prior_star))
    else $error("end of input did not return scanner to idle");
`endif

endmodule

`default_nettype wire

// ===== tb/token_checker.sv =====
// Token checker for the small-language lexer: watches the input and output channels,
// predicts the token stream from the accepted source bytes and compares it.
// Depends on sll_pkg for the mode enum, token codes, error kinds and res_t.
`timescale 1ns / 1ps

module token_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  input_char,
  input  logic        end_of_input,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  token_code,
  input  logic [1:0]  error_kind,
  input  logic [3:0]  lexeme_length,
  input  logic [63:0] lexeme_head,
  input  logic [23:0] lexeme_tail,
  input  logic        last_of_run,
  output int          mismatches,
  output int          outstanding
);
  import sll_pkg::*;

  mode_t      scan_state;
  logic       star_seen;
  logic [7:0] lex_buf [BufDepth];
  int         lex_cnt;

  res_t       step_tok [2];
  int         step_cnt;
  res_t       expected_tokens [$];

  function automatic logic is_letter(logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic logic is_blank(logic [7:0] ch);
    return ch == " " || (ch >= 8'h09 && ch <= 8'h0D);
  endfunction

  // Reserved words are letters only, so the packed bytes also fix the length
  function automatic logic [5:0] keyword_code();
    logic [39:0] w;
    w = '0;
    if (lex_cnt > 5) return TokIdent;
    for (int i = 0; i < lex_cnt; i++) w = {w[31:0], lex_buf[i]};
    case (w)
      40'("const"): return TokConst;
      40'("var"):   return TokVar;
      40'("begin"): return TokBegin;
      40'("end"):   return TokEnd;
      40'("if"):    return TokIf;
      40'("fi"):    return TokFi;
      40'("then"):  return TokThen;
      40'("else"):  return TokElse;
      40'("while"): return TokWhile;
      40'("do"):    return TokDo;
      40'("read"):  return TokRead;
      40'("write"): return TokWrite;
      40'("mod"):   return TokMod;
      default:      return TokIdent;
    endcase
  endfunction

  task automatic emit_lexeme(input logic [5:0] code, input logic [1:0] kind);
    logic [BufDepth*8-1:0] text;
    res_t t;
    text = '0;
    for (int i = 0; i < lex_cnt; i++) text[8*i +: 8] = lex_buf[i];
    t = '0;
    t.token_code    = code;
    t.error_kind    = kind;
    t.lexeme_length = 4'(lex_cnt);
    t.lexeme_head   = text[63:0];
    t.lexeme_tail   = text[BufDepth*8-1:64];
    step_tok[step_cnt] = t;
    step_cnt++;
  endtask

  task automatic emit_char(input logic [5:0] code, input logic [1:0] kind,
                           input logic [7:0] ch);
    res_t t;
    t = '0;
    t.token_code    = code;
    t.error_kind    = kind;
    t.lexeme_length = 4'd1;
    t.lexeme_head   = 64'(ch);
    step_tok[step_cnt] = t;
    step_cnt++;
  endtask

  task automatic emit_pair(input logic [5:0] code, input logic [7:0] a, input logic [7:0] b);
    res_t t;
    t = '0;
    t.token_code    = code;
    t.error_kind    = ErrNone;
    t.lexeme_length = 4'd2;
    t.lexeme_head   = {48'h0, b, a};
    step_tok[step_cnt] = t;
    step_cnt++;
  endtask

  task automatic begin_token(input logic [7:0] ch);
    scan_state = MODE_IDLE;
    if (is_letter(ch) || is_digit(ch)) begin
      lex_buf[0] = ch;
      lex_cnt    = 1;
      scan_state = is_letter(ch) ? MODE_IDENT : MODE_NUM;
    end else if (!is_blank(ch)) begin
      case (ch)
        "/": scan_state = MODE_SLASH;
        ":": scan_state = MODE_COLON;
        "<": scan_state = MODE_LESS;
        ">": scan_state = MODE_GREATER;
        "+": emit_char(TokPlus, ErrNone, ch);
        "-": emit_char(TokMinus, ErrNone, ch);
        "*": emit_char(TokStar, ErrNone, ch);
        "(": emit_char(TokLParen, ErrNone, ch);
        ")": emit_char(TokRParen, ErrNone, ch);
        "=": emit_char(TokEq, ErrNone, ch);
        ",": emit_char(TokComma, ErrNone, ch);
        ".": emit_char(TokPeriod, ErrNone, ch);
        ";": emit_char(TokSemi, ErrNone, ch);
        default: emit_char(TokError, ErrSymbol, ch);
      endcase
    end
  endtask

  task automatic scan_request(input logic [7:0] ch, input logic eoi);
    step_cnt = 0;
    if (eoi) begin
      // flush whatever is pending; a run being dropped gives nothing
      case (scan_state)
        MODE_IDENT:   emit_lexeme(keyword_code(), ErrNone);
        MODE_NUM:     emit_lexeme(TokNumber, ErrNone);
        MODE_SLASH:   emit_char(TokSlash, ErrNone, "/");
        MODE_COMMENT: begin
          emit_char(TokSlash, ErrNone, "/");
          emit_char(TokStar, ErrNone, "*");
        end
        MODE_COLON:   emit_char(TokError, ErrSymbol, ":");
        MODE_LESS:    emit_char(TokLt, ErrNone, "<");
        MODE_GREATER: emit_char(TokGt, ErrNone, ">");
        default: ;
      endcase
      scan_state = MODE_IDLE;
      star_seen  = 1'b0;
      lex_cnt    = 0;
    end else begin
      case (scan_state)
        MODE_IDENT: begin
          if (is_letter(ch) || is_digit(ch)) begin
            if (lex_cnt < IdentLimit) begin
              lex_buf[lex_cnt] = ch;
              lex_cnt++;
            end else begin
              emit_lexeme(TokError, ErrIdentLong);
              scan_state = MODE_IDSKIP;
            end
          end else begin
            emit_lexeme(keyword_code(), ErrNone);
            begin_token(ch);
          end
        end
        MODE_IDSKIP: begin
          if (!(is_letter(ch) || is_digit(ch))) begin_token(ch);
        end
        MODE_NUM: begin
          if (is_digit(ch)) begin
            if (lex_cnt < NumberLimit) begin
              lex_buf[lex_cnt] = ch;
              lex_cnt++;
            end else begin
              emit_lexeme(TokError, ErrNumLong);
              scan_state = MODE_NUMSKIP;
            end
          end else begin
            emit_lexeme(TokNumber, ErrNone);
            begin_token(ch);
          end
        end
        MODE_NUMSKIP: begin
          if (!is_digit(ch)) begin_token(ch);
        end
        MODE_SLASH: begin
          if (ch == "*") begin
            scan_state = MODE_COMMENT;
            star_seen  = 1'b0;
          end else begin
            emit_char(TokSlash, ErrNone, "/");
            begin_token(ch);
          end
        end
        MODE_COMMENT: begin
          if (star_seen && ch == "/") begin
            scan_state = MODE_IDLE;
            star_seen  = 1'b0;
          end else begin
            star_seen = (ch == "*");
          end
        end
        MODE_COLON: begin
          if (ch == "=") begin
            emit_pair(TokBecomes, ":", "=");
            scan_state = MODE_IDLE;
          end else begin
            emit_char(TokError, ErrSymbol, ":");
            begin_token(ch);
          end
        end
        MODE_LESS: begin
          if (ch == "=") begin
            emit_pair(TokLe, "<", "=");
            scan_state = MODE_IDLE;
          end else if (ch == ">") begin
            emit_pair(TokNe, "<", ">");
            scan_state = MODE_IDLE;
          end else begin
            emit_char(TokLt, ErrNone, "<");
            begin_token(ch);
          end
        end
        MODE_GREATER: begin
          if (ch == "=") begin
            emit_pair(TokGe, ">", "=");
            scan_state = MODE_IDLE;
          end else begin
            emit_char(TokGt, ErrNone, ">");
            begin_token(ch);
          end
        end
        default: begin_token(ch);
      endcase
    end
    for (int i = 0; i < step_cnt; i++) begin
      if (i == step_cnt - 1) step_tok[i].last_of_run = 1'b1;
      expected_tokens.push_back(step_tok[i]);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $time, field, got, want);
    mismatches++;
  endtask

  task automatic check_token();
    res_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch("unexpected token, token_code", 64'(token_code), 64'h0);
    end else begin
      want = expected_tokens.pop_front();
      if (token_code !== want.token_code)
        report_mismatch("token_code", 64'(token_code), 64'(want.token_code));
      if (error_kind !== want.error_kind)
        report_mismatch("error_kind", 64'(error_kind), 64'(want.error_kind));
      if (lexeme_length !== want.lexeme_length)
        report_mismatch("lexeme_length", 64'(lexeme_length), 64'(want.lexeme_length));
      if (lexeme_head !== want.lexeme_head)
        report_mismatch("lexeme_head", lexeme_head, want.lexeme_head);
      if (lexeme_tail !== want.lexeme_tail)
        report_mismatch("lexeme_tail", 64'(lexeme_tail), 64'(want.lexeme_tail));
      if (last_of_run !== want.last_of_run)
        report_mismatch("last_of_run", 64'(last_of_run), 64'(want.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scan_state = MODE_IDLE;
      star_seen  = 1'b0;
      lex_cnt    = 0;
      mismatches = 0;
      expected_tokens.delete();
    end else begin
      // a request accepted now can only show up from the next cycle on
      if (out_valid && !out_stall) check_token();
      if (in_valid && !in_stall) scan_request(input_char, end_of_input);
    end
    outstanding = expected_tokens.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the lexer testbench: clock, reset, source-byte stimulus, output stalls
// and the verdict. Depends on small_language_lexer_top and token_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int ItemTarget = 2000;
  localparam int QuietStart = 1500;
  localparam int QuietEnd   = 2100;
  localparam int HoldStart  = 600;
  localparam int HoldLen    = 300;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  input_char;
  logic        end_of_input;
  logic        out_valid;
  logic        out_stall;
  logic [5:0]  token_code;
  logic [1:0]  error_kind;
  logic [3:0]  lexeme_length;
  logic [63:0] lexeme_head;
  logic [23:0] lexeme_tail;
  logic        last_of_run;
  int          mismatches;
  int          outstanding;

  int unsigned cyc = 0;
  int          sent;

  string keywords [13] = '{"const", "var", "begin", "end", "if", "fi", "then", "else",
                           "while", "do", "read", "write", "mod"};
  string operators [17] = '{"+", "-", "*", "/", "(", ")", "=", ",", ".", ";",
                            ":=", "<", "<=", "<>", ">", ">=", ":"};
  logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  small_language_lexer_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .input_char    (input_char),
    .end_of_input  (end_of_input),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_code    (token_code),
    .error_kind    (error_kind),
    .lexeme_length (lexeme_length),
    .lexeme_head   (lexeme_head),
    .lexeme_tail   (lexeme_tail),
    .last_of_run   (last_of_run)
  );

  token_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .input_char    (input_char),
    .end_of_input  (end_of_input),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_code    (token_code),
    .error_kind    (error_kind),
    .lexeme_length (lexeme_length),
    .lexeme_head   (lexeme_head),
    .lexeme_tail   (lexeme_tail),
    .last_of_run   (last_of_run),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  function automatic bit gaps_allowed(int unsigned n);
    return !(n >= QuietStart && n < QuietEnd);
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'("a" + $urandom_range(25)) : 8'("A" + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(9));
  endfunction

  // Offer one request from a falling edge and hold it until accepted
  task automatic send_request(input logic [7:0] ch, input logic eoi);
    while (gaps_allowed(cyc) && $urandom_range(99) < 36) begin
      in_valid     = 1'b0;
      input_char   = 8'($urandom_range(255));
      end_of_input = 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid     = 1'b1;
    input_char   = ch;
    end_of_input = eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  task automatic send_random_lexeme();
    int pick;
    int len;
    bit is_word;
    pick    = $urandom_range(99);
    is_word = 1'b0;
    if (pick < 18) begin
      send_text(keywords[$urandom_range(12)]);
      is_word = 1'b1;
    end else if (pick < 36) begin
      // mostly legal lengths, now and then past the identifier limit
      len = ($urandom_range(9) == 0) ? $urandom_range(14, 12) : $urandom_range(11, 1);
      send_request(rand_letter(), 1'b0);
      repeat (len - 1) send_request($urandom_range(2) ? rand_letter() : rand_digit(), 1'b0);
      is_word = 1'b1;
    end else if (pick < 48) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(8, 6) : $urandom_range(5, 1);
      repeat (len) send_request(rand_digit(), 1'b0);
      is_word = 1'b1;
    end else if (pick < 70) begin
      send_text(operators[$urandom_range(16)]);
    end else if (pick < 78) begin
      send_text("/*");
      repeat ($urandom_range(6)) begin
        case ($urandom_range(3))
          0:       send_request("*", 1'b0);
          1:       send_request("/", 1'b0);
          default: send_request(8'($urandom_range(255)), 1'b0);
        endcase
      end
      if ($urandom_range(9) != 0) send_text("*/");
    end else if (pick < 92) begin
      repeat ($urandom_range(3, 1)) send_request(blanks[$urandom_range(5)], 1'b0);
    end else if (pick < 98) begin
      send_request(8'($urandom_range(255)), 1'b0);
    end else begin
      send_request(8'($urandom_range(255)), 1'b1);
    end
    if (is_word && $urandom_range(9) < 7) send_request(blanks[$urandom_range(5)], 1'b0);
  endtask

  // Receiver: random stalls, one long hold-off so the block backs up its input
  initial begin
    int unsigned n;
    n         = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n++;
      if (n >= HoldStart && n < HoldStart + HoldLen) out_stall = 1'b1;
      else if (gaps_allowed(n)) out_stall = ($urandom_range(99) < 36);
      else out_stall = 1'b0;
    end
  end

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    input_char   = 8'h00;
    end_of_input = 1'b0;
    sent         = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: byte extremes, lone colon, compound operators, comment edges,
    // overlong number dropped at end of input, comment left open at end
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_text(":a<>>=/*/*/");
    send_text("123456");
    send_request(8'h00, 1'b1);
    send_text("/*");
    send_request(8'hAA, 1'b1);

    while (sent < ItemTarget) send_random_lexeme();
    send_request(8'h55, 1'b1);
    in_valid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/sll_pkg.sv
rtl/small_language_lexer_top.sv
tb/token_checker.sv
tb/testbench.sv
